FILE: hdl/stereo_pan_mix_accumulator_top_assert.svh
// ----------------------------------------------------------------------------
// stereo_pan_mix_accumulator_top_assert.svh
// Assertion macros for the checker file of the stereo mixer.
// ----------------------------------------------------------------------------
`ifndef STEREO_PAN_MIX_ACCUMULATOR_TOP_ASSERT_SVH
`define STEREO_PAN_MIX_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset
`define SPM_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset
`define SPM_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants, types and saturation helpers of the stereo pan mixer.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Sizing
    localparam int NUM_SOURCES = 4;
    localparam int NUM_REGS    = 4;
    localparam int MAX_FRAMES  = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int ACC_BITS    = SAMPLE_BITS + 2;
    localparam int MEM_W       = 2 * ACC_BITS;
    localparam int ADDR_W      = $clog2(MAX_FRAMES);

    // Field widths
    localparam int FRAME_W = 10;
    localparam int BLK_W   = 11;
    localparam int SRC_W   = 2;
    localparam int SET_W   = 34;
    localparam int INDEX_W = 2;
    localparam int GAIN_W  = 16;
    localparam int PAN_W   = 16;
    localparam int FACT_W  = 15;
    localparam int COEF_W  = 16;
    localparam int TERM_W  = SAMPLE_BITS + 1;

    // Settings word layout
    localparam int SET_PRESENT_BIT = 33;
    localparam int SET_MUTED_BIT   = 32;
    localparam int SET_PAN_LSB     = 16;
    localparam int SET_GAIN_LSB    = 0;

    // Fixed-point constants
    localparam int UNITY_GAIN = 32768;
    localparam int UNITY_PAN  = 16384;
    localparam int COEF_SHIFT = 14;
    localparam int COEF_RND   = 8192;
    localparam int TERM_SHIFT = 15;
    localparam int TERM_RND   = 16384;

    // Operation codes
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_MIX   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COEF,
        ST_SCALE,
        ST_COMMIT
    } state_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic              busy;
        logic              accept;
        logic              coef_en;
        logic              scale_en;
        logic              commit;
        logic              clear_we;
        logic [ADDR_W-1:0] clear_addr;
    } ctrl_t;

    // Saturate an accumulator sum with one guard bit to ACC_BITS
    function automatic logic signed [ACC_BITS-1:0] sat_acc(
        input logic signed [ACC_BITS:0] v);
        logic signed [ACC_BITS-1:0] r;
        if (v[ACC_BITS] != v[ACC_BITS-1])
            r = {v[ACC_BITS], {(ACC_BITS-1){~v[ACC_BITS]}}};
        else
            r = v[ACC_BITS-1:0];
        return r;
    endfunction

    // Saturate an accumulator entry to the output sample width
    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
        input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-SAMPLE_BITS:0] top;
        logic signed [SAMPLE_BITS-1:0] r;
        top = v[ACC_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            r = v[SAMPLE_BITS-1:0];
        else
            r = {v[ACC_BITS-1], {(SAMPLE_BITS-1){~v[ACC_BITS-1]}}};
        return r;
    endfunction

endpackage

FILE: hdl/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/spm_scale.sv
// ----------------------------------------------------------------------------
// spm_scale
// Pan law and gain: left/right coefficients, then scaled sample terms.
// ----------------------------------------------------------------------------
module spm_scale (
    input  logic                                   clk,
    input  logic                                   coef_en,
    input  logic                                   scale_en,
    input  logic [spm_pkg::SET_W-1:0]              settings,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0] right_sample,
    output logic signed [spm_pkg::TERM_W-1:0]      term_left,
    output logic signed [spm_pkg::TERM_W-1:0]      term_right
);

    localparam int CPROD_W = spm_pkg::GAIN_W + spm_pkg::FACT_W;
    localparam int SPROD_W = spm_pkg::SAMPLE_BITS + spm_pkg::COEF_W + 1;

    logic [spm_pkg::GAIN_W-1:0]        gain_raw;
    logic [spm_pkg::GAIN_W-1:0]        gain;
    logic signed [spm_pkg::PAN_W-1:0]  pan_raw;
    logic signed [spm_pkg::PAN_W-1:0]  pan;
    logic signed [spm_pkg::PAN_W-1:0]  lf_full;
    logic signed [spm_pkg::PAN_W-1:0]  rf_full;
    logic [spm_pkg::FACT_W-1:0]        lf;
    logic [spm_pkg::FACT_W-1:0]        rf;
    logic [CPROD_W-1:0]                lc_sum;
    logic [CPROD_W-1:0]                rc_sum;
    logic [spm_pkg::COEF_W-1:0]        lc_reg;
    logic [spm_pkg::COEF_W-1:0]        rc_reg;
    logic signed [SPROD_W-1:0]         lt_sum;
    logic signed [SPROD_W-1:0]         rt_sum;
    logic signed [spm_pkg::TERM_W-1:0] term_left_reg;
    logic signed [spm_pkg::TERM_W-1:0] term_right_reg;

    // Clamp gain to unity and pan to -1..+1
    always_comb
    begin
        gain_raw = settings[spm_pkg::SET_GAIN_LSB +: spm_pkg::GAIN_W];
        pan_raw  = $signed(settings[spm_pkg::SET_PAN_LSB +: spm_pkg::PAN_W]);
        if (gain_raw > spm_pkg::GAIN_W'(spm_pkg::UNITY_GAIN))
            gain = spm_pkg::GAIN_W'(spm_pkg::UNITY_GAIN);
        else
            gain = gain_raw;
        if (pan_raw > $signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN)))
            pan = $signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN));
        else if (pan_raw < -$signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN)))
            pan = -$signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN));
        else
            pan = pan_raw;
    end

    // Linear pan: positive pan cuts left only, negative pan cuts right only
    always_comb
    begin
        lf_full = $signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN));
        rf_full = $signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN));
        if (pan > 0)
            lf_full = $signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN)) - pan;
        if (pan < 0)
            rf_full = $signed(spm_pkg::PAN_W'(spm_pkg::UNITY_PAN)) + pan;
        lf = lf_full[spm_pkg::FACT_W-1:0];
        rf = rf_full[spm_pkg::FACT_W-1:0];
    end

    // Coefficient stage: gain times pan factor, rounded to Q1.15
    assign lc_sum = CPROD_W'(gain) * CPROD_W'(lf) + CPROD_W'(spm_pkg::COEF_RND);
    assign rc_sum = CPROD_W'(gain) * CPROD_W'(rf) + CPROD_W'(spm_pkg::COEF_RND);

    always_ff @(posedge clk)
    begin
        if (coef_en)
        begin
            lc_reg <= spm_pkg::COEF_W'(lc_sum >> spm_pkg::COEF_SHIFT);
            rc_reg <= spm_pkg::COEF_W'(rc_sum >> spm_pkg::COEF_SHIFT);
        end
    end

    // Scale stage: sample times coefficient, round half up
    assign lt_sum = SPROD_W'(left_sample) * $signed({1'b0, lc_reg})
                  + SPROD_W'(spm_pkg::TERM_RND);
    assign rt_sum = SPROD_W'(right_sample) * $signed({1'b0, rc_reg})
                  + SPROD_W'(spm_pkg::TERM_RND);

    always_ff @(posedge clk)
    begin
        if (scale_en)
        begin
            term_left_reg  <= spm_pkg::TERM_W'(lt_sum >>> spm_pkg::TERM_SHIFT);
            term_right_reg <= spm_pkg::TERM_W'(rt_sum >>> spm_pkg::TERM_SHIFT);
        end
    end

    assign term_left  = term_left_reg;
    assign term_right = term_right_reg;

endmodule

FILE: hdl/spm_ctrl.sv
// ----------------------------------------------------------------------------
// spm_ctrl
// Sequencer: post-reset clearing sweep, then an item sequence of coefficient, scale and commit states.
// ----------------------------------------------------------------------------
module spm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output spm_pkg::ctrl_t  ctrl
);

    spm_pkg::state_t                state_reg;
    spm_pkg::state_t                state_next;
    logic [spm_pkg::ADDR_W-1:0]     clr_cnt_reg;
    logic [spm_pkg::ADDR_W-1:0]     clr_cnt_next;
    logic                           clr_last;

    assign clr_last = (clr_cnt_reg == spm_pkg::ADDR_W'(spm_pkg::MAX_FRAMES - 1));

    // State and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= spm_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            spm_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                    state_next = spm_pkg::ST_IDLE;
            end
            spm_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = spm_pkg::ST_COEF;
            end
            spm_pkg::ST_COEF:   state_next = spm_pkg::ST_SCALE;
            spm_pkg::ST_SCALE:  state_next = spm_pkg::ST_COMMIT;
            spm_pkg::ST_COMMIT: state_next = spm_pkg::ST_IDLE;
            default:            state_next = spm_pkg::ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl            = '0;
        ctrl.clear_addr = clr_cnt_reg;
        case (state_reg)
            spm_pkg::ST_CLEAR:
            begin
                ctrl.busy     = 1'b1;
                ctrl.clear_we = 1'b1;
            end
            spm_pkg::ST_IDLE:
            begin
                ctrl.accept = start;
            end
            spm_pkg::ST_COEF:
            begin
                ctrl.busy    = 1'b1;
                ctrl.coef_en = 1'b1;
            end
            spm_pkg::ST_SCALE:
            begin
                ctrl.busy     = 1'b1;
                ctrl.scale_en = 1'b1;
            end
            spm_pkg::ST_COMMIT:
            begin
                ctrl.busy   = 1'b1;
                ctrl.commit = 1'b1;
            end
            default:
            begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: hdl/stereo_pan_mix_accumulator_top.sv
// ----------------------------------------------------------------------------
// stereo_pan_mix_accumulator_top
// Stereo mixer with linear pan and a per-frame accumulator memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (op, source, frame_index, block_frames,
//   left_sample, right_sample) is taken at a clock edge with start high and
//   busy low. op 0 accumulates a panned, gained stereo sample into the
//   frame's entry; op 1 reads the frame out saturated and clears the entry.
//   Result channel: one word per mix command on out_frame_index, out_left,
//   out_right, marked by result_valid for exactly one cycle. The receiver
//   cannot stall; the word must be taken in that cycle.
//   Sequence: busy stays high from acceptance until the command is through,
//   so the block takes no new command while one is in flight. Each command
//   passes the memory read, the coefficient multiply, the sample multiply
//   and the write-back in that order over the single accumulator RAM;
//   result_valid is registered from the write-back state.
//   Reset: settings registers and the high-water size go to zero, and a
//   clearing sweep zeroes the 1024-entry accumulator, one entry a cycle;
//   busy stays high until the sweep ends. Settings writes (cfg_we,
//   cfg_index, cfg_data) take effect at once and may be made at any idle time.
// ----------------------------------------------------------------------------
module stereo_pan_mix_accumulator_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Settings write port
    input  logic                                   cfg_we,
    input  logic [spm_pkg::INDEX_W-1:0]            cfg_index,
    input  logic [spm_pkg::SET_W-1:0]              cfg_data,
    // Command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   op,
    input  logic [spm_pkg::SRC_W-1:0]              source,
    input  logic [spm_pkg::FRAME_W-1:0]            frame_index,
    input  logic [spm_pkg::BLK_W-1:0]              block_frames,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0] right_sample,
    // Result channel
    output logic                                   result_valid,
    output logic [spm_pkg::FRAME_W-1:0]            out_frame_index,
    output logic signed [spm_pkg::SAMPLE_BITS-1:0] out_left,
    output logic signed [spm_pkg::SAMPLE_BITS-1:0] out_right
);

    spm_pkg::ctrl_t                        ctrl;

    logic [spm_pkg::SET_W-1:0]             settings_reg [spm_pkg::NUM_REGS];
    logic [spm_pkg::BLK_W-1:0]             high_water_reg;
    logic [spm_pkg::BLK_W-1:0]             high_water_next;

    // Latched command word
    logic                                  op_reg;
    logic [spm_pkg::SRC_W-1:0]             src_reg;
    logic [spm_pkg::FRAME_W-1:0]           fi_reg;
    logic [spm_pkg::BLK_W-1:0]             blk_reg;
    logic [spm_pkg::SET_W-1:0]             set_reg;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] left_reg;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] right_reg;
    logic [spm_pkg::BLK_W-1:0]             blk_eff;

    // Memory and datapath
    logic                                  mem_we;
    logic [spm_pkg::ADDR_W-1:0]            mem_waddr;
    logic [spm_pkg::MEM_W-1:0]             mem_wdata;
    logic [spm_pkg::MEM_W-1:0]             mem_rdata;
    logic signed [spm_pkg::TERM_W-1:0]     term_left;
    logic signed [spm_pkg::TERM_W-1:0]     term_right;
    logic signed [spm_pkg::ACC_BITS-1:0]   acc_left;
    logic signed [spm_pkg::ACC_BITS-1:0]   acc_right;
    logic signed [spm_pkg::ACC_BITS:0]     sum_left;
    logic signed [spm_pkg::ACC_BITS:0]     sum_right;
    logic                                  apply_acc;
    logic                                  do_mix;
    logic                                  hw_ok;

    // Output registers
    logic                                  result_valid_reg;
    logic                                  result_valid_next;
    logic [spm_pkg::FRAME_W-1:0]           out_fi_reg;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] out_left_reg;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] out_right_reg;

    // Sequencer
    spm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ctrl  (ctrl)
    );

    assign busy = ctrl.busy;

    // Settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spm_pkg::NUM_REGS; i++)
                settings_reg[i] <= '0;
        end
        else if (cfg_we && (32'(cfg_index) < spm_pkg::NUM_REGS))
        begin
            settings_reg[cfg_index] <= cfg_data;
        end
    end

    // Clamp block size to the storage depth
    always_comb
    begin
        if (block_frames > spm_pkg::BLK_W'(spm_pkg::MAX_FRAMES))
            blk_eff = spm_pkg::BLK_W'(spm_pkg::MAX_FRAMES);
        else
            blk_eff = block_frames;
    end

    // Capture the command word
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            op_reg    <= op;
            src_reg   <= source;
            fi_reg    <= frame_index;
            blk_reg   <= blk_eff;
            set_reg   <= settings_reg[source];
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
    end

    // Coefficient and scaling pipeline
    spm_scale u_scale (
        .clk          (clk),
        .coef_en      (ctrl.coef_en),
        .scale_en     (ctrl.scale_en),
        .settings     (set_reg),
        .left_sample  (left_reg),
        .right_sample (right_reg),
        .term_left    (term_left),
        .term_right   (term_right)
    );

    // Accumulator memory: left sum low, right sum high
    spm_ram #(
        .WIDTH (spm_pkg::MEM_W),
        .DEPTH (spm_pkg::MAX_FRAMES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (ctrl.accept),
        .raddr (frame_index[spm_pkg::ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    assign acc_left  = $signed(mem_rdata[spm_pkg::ACC_BITS-1:0]);
    assign acc_right = $signed(mem_rdata[spm_pkg::MEM_W-1:spm_pkg::ACC_BITS]);

    // Decide the item's effect
    assign apply_acc = (op_reg == spm_pkg::OP_ACCUM)
                    && (32'(src_reg) < spm_pkg::NUM_SOURCES)
                    && set_reg[spm_pkg::SET_PRESENT_BIT]
                    && !set_reg[spm_pkg::SET_MUTED_BIT]
                    && ({1'b0, fi_reg} < blk_reg);
    assign do_mix = (op_reg == spm_pkg::OP_MIX);
    assign hw_ok  = (blk_reg <= high_water_reg);

    // Add scaled terms, saturate to the accumulator width
    assign sum_left  = (spm_pkg::ACC_BITS+1)'(acc_left) + (spm_pkg::ACC_BITS+1)'(term_left);
    assign sum_right = (spm_pkg::ACC_BITS+1)'(acc_right)
                     + (spm_pkg::ACC_BITS+1)'(term_right);

    // Memory write: clearing sweep, accumulate, or clear after mix
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fi_reg[spm_pkg::ADDR_W-1:0];
        mem_wdata = '0;
        if (ctrl.clear_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = ctrl.clear_addr;
        end
        else if (ctrl.commit && apply_acc)
        begin
            mem_we    = 1'b1;
            mem_wdata = {spm_pkg::sat_acc(sum_right), spm_pkg::sat_acc(sum_left)};
        end
        else if (ctrl.commit && do_mix)
        begin
            mem_we = 1'b1;
        end
    end

    // High-water block size
    always_comb
    begin
        high_water_next = high_water_reg;
        if (ctrl.commit && apply_acc && (blk_reg > high_water_reg))
            high_water_next = blk_reg;
    end

    assign result_valid_next = ctrl.commit && do_mix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_water_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            high_water_reg   <= high_water_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (result_valid_next)
        begin
            out_fi_reg <= fi_reg;
            if (hw_ok)
            begin
                out_left_reg  <= spm_pkg::sat_out(acc_left);
                out_right_reg <= spm_pkg::sat_out(acc_right);
            end
            else
            begin
                out_left_reg  <= '0;
                out_right_reg <= '0;
            end
        end
    end

    assign result_valid    = result_valid_reg;
    assign out_frame_index = out_fi_reg;
    assign out_left        = out_left_reg;
    assign out_right       = out_right_reg;

endmodule

FILE: hdl/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks of the stereo mixer's command and result timing.
// ----------------------------------------------------------------------------
`include "stereo_pan_mix_accumulator_top_assert.svh"

module spm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          op,
    input logic [spm_pkg::FRAME_W-1:0]   frame_index,
    input logic                          result_valid,
    input logic [spm_pkg::FRAME_W-1:0]   out_frame_index
);

    logic                          mix_acc;
    logic                          accum_acc;
    logic                          fi_match;
    logic [spm_pkg::FRAME_W-1:0]   fi_hist_reg [4];

    // Accepted words by kind
    assign mix_acc   = start && !busy && (op == spm_pkg::OP_MIX);
    assign accum_acc = start && !busy && (op == spm_pkg::OP_ACCUM);

    // History of past frame indices; the oldest is compared with the result
    always_ff @(posedge clk)
    begin
        fi_hist_reg[0] <= frame_index;
        for (int i = 1; i < 4; i++)
            fi_hist_reg[i] <= fi_hist_reg[i-1];
    end

    assign fi_match = (out_frame_index == fi_hist_reg[3]);

    // A result is only shown while the block is ready for a new word
    `SPM_ASSERT_SAME(a_result_when_idle, result_valid, !busy, "result while busy")

    // An accepted word makes the block busy
    `SPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")

    // Mix words answer with a result that carries their own frame index
    `SPM_ASSERT_SAME(a_mix_result, mix_acc, ##4 (result_valid && fi_match), "bad mix result")

    // Accumulate words give no result
    `SPM_ASSERT_SAME(a_accum_silent, accum_acc, ##4 !result_valid, "result from accumulate")

endmodule

bind stereo_pan_mix_accumulator_top spm_checker u_spm_checker (.*);
